// ===== design/bbps_pkg.sv =====
// Shared types and constants of the bucket bitmap priority set.
// No dependencies; imported by every other file of the block.
package bbps_pkg;

  localparam int unsigned NumBuckets = 16;
  localparam int unsigned BucketW    = 4;
  localparam int unsigned ValueRange = 256;
  localparam int unsigned MemberW    = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned BitW       = 5;
  localparam int unsigned Words      = (ValueRange + WordW - 1) / WordW;
  localparam int unsigned WordIdxW   = 3;
  localparam int unsigned LwW        = WordIdxW + 1;
  localparam int unsigned AddrW      = BucketW + WordIdxW;
  localparam int unsigned LowW       = 9;
  localparam int unsigned Depth      = NumBuckets * Words;

  localparam logic [LwW-1:0]  LwEmpty  = LwW'(Words);
  localparam logic [LowW-1:0] LowEmpty = LowW'(ValueRange);

  // request action codes; the fourth code is unused
  localparam logic [1:0] ActToggle = 2'd0;
  localparam logic [1:0] ActLowest = 2'd1;
  localparam logic [1:0] ActPeek   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [BucketW-1:0] bucket;
    logic [MemberW-1:0] member;
  } req_t;

  typedef struct packed {
    logic               now_present;
    logic [BucketW-1:0] bucket_out;
    logic [LowW-1:0]    lowest_member;
    logic               all_empty;
  } rsp_t;

endpackage

// ===== design/bbps_word_ram.sv =====
// Bitmap word store: one write port, one registered read port.
// Per-entry valid bits make every word read as zero after reset. Uses bbps_pkg.
module bbps_word_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [bbps_pkg::AddrW-1:0]  waddr_i,
  input  logic [bbps_pkg::WordW-1:0]  wdata_i,
  input  logic [bbps_pkg::AddrW-1:0]  raddr_i,
  output logic [bbps_pkg::WordW-1:0]  rdata_o
);
  import bbps_pkg::*;

  logic [WordW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [WordW-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== design/bbps_ffs.sv =====
// Find-first-set over one bitmap word, as a five-level halving tree.
// Shared by zero tests and lowest-member lookup. Uses bbps_pkg.
module bbps_ffs (
  input  logic [bbps_pkg::WordW-1:0] word_i,
  output logic                       zero_o,
  output logic [bbps_pkg::BitW-1:0]  pos_o
);
  import bbps_pkg::*;

  logic [15:0] w16;
  logic [7:0]  w8;
  logic [3:0]  w4;
  logic [1:0]  w2;

  always_comb begin
    pos_o[4] = ~|word_i[15:0];
    w16      = pos_o[4] ? word_i[31:16] : word_i[15:0];
    pos_o[3] = ~|w16[7:0];
    w8       = pos_o[3] ? w16[15:8] : w16[7:0];
    pos_o[2] = ~|w8[3:0];
    w4       = pos_o[2] ? w8[7:4] : w8[3:0];
    pos_o[1] = ~|w4[1:0];
    w2       = pos_o[1] ? w4[3:2] : w4[1:0];
    pos_o[0] = ~w2[0];
    zero_o   = ~|word_i;
  end

endmodule

// ===== design/bucket_bitmap_priority_set_unit.sv =====
// Bucket bitmap priority set: 16 buckets, each a 256-value bitmap in eight
// 32-bit words. A request toggles a value (action 0), asks for the lowest
// member of a bucket (action 1) or peeks the highest non-empty bucket
// (action 2); each request gives exactly one response. One request is in
// work at a time: in_ready_o is high only while the sequencer is idle, and a
// finished response sits in the output register while the next request is
// taken, and a stalled one there holds back the next. A query reads the
// lowest-word table, then the bitmap word, then runs find-first-set, which
// an empty bucket skips; the unused action goes straight to the output. A
// toggle reads and writes the word, and before answering like a query it
// rescans upward when the lowest word empties (up to 7 words) and walks
// down when the top bucket empties (up to 16). The cost is set by the single
// registered read port of the word memory and the one find-first-set unit
// that serves every word test. The memory needs no clearing pass after reset.
module bucket_bitmap_priority_set_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bbps_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bbps_pkg::rsp_t out_rsp_o
);
  import bbps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRD, S_TWR, S_SRD, S_SCK, S_TOP, S_TSC,
    S_QLW, S_QRD, S_QFF, S_EMP, S_OUT
  } state_e;

  state_e               state_q;
  req_t                 req_q;
  logic [LwW-1:0]       lw_q [NumBuckets];  // lowest non-empty word, LwEmpty = none
  logic [BucketW-1:0]   top_q;
  logic [LwW-1:0]       lw_cur_q;
  logic                 now_q;
  logic [LwW-1:0]       scan_q;
  logic [BucketW-1:0]   tscan_q;
  logic [BucketW-1:0]   bout_q;
  logic [LowW-1:0]      low_q;
  logic                 empty_q;
  logic                 out_valid_q;
  rsp_t                 out_q;

  logic [WordIdxW-1:0]  word_idx;
  logic [BitW-1:0]      bit_idx;
  logic [WordW-1:0]     mask;
  logic [WordW-1:0]     rdata;
  logic [WordW-1:0]     new_word;
  logic [AddrW-1:0]     raddr;
  logic                 we;
  logic [WordW-1:0]     ffs_word;
  logic                 ffs_zero;
  logic [BitW-1:0]      ffs_pos;
  logic [BucketW-1:0]   lw_addr;
  logic [LwW-1:0]       lw_rd;
  logic [BucketW-1:0]   bout_sel;
  logic [LwW-1:0]       word_ext;
  logic [LwW-1:0]       next_word;
  logic [LwW-1:0]       next_scan;

  assign word_idx  = req_q.member[BitW +: WordIdxW];
  assign bit_idx   = req_q.member[BitW-1:0];
  assign mask      = WordW'(1) << bit_idx;
  assign new_word  = rdata ^ mask;
  assign word_ext  = {1'b0, word_idx};
  assign next_word = word_ext + LwW'(1);
  assign next_scan = scan_q + LwW'(1);
  assign bout_sel  = (req_q.action == ActPeek) ? top_q : req_q.bucket;
  assign we        = (state_q == S_TWR);

  // one word-memory read address per cycle; data shows up in the next state
  always_comb begin
    case (state_q)
      S_SRD:   raddr = {req_q.bucket, scan_q[WordIdxW-1:0]};
      S_QRD:   raddr = {bout_q, lw_cur_q[WordIdxW-1:0]};
      default: raddr = {req_q.bucket, word_idx};
    endcase
  end

  // one lowest-word read per cycle
  always_comb begin
    case (state_q)
      S_TSC:   lw_addr = tscan_q;
      S_QLW:   lw_addr = bout_sel;
      S_EMP:   lw_addr = top_q;
      default: lw_addr = req_q.bucket;
    endcase
  end
  assign lw_rd = lw_q[lw_addr];

  // the shared word unit sees the updated word during the write step
  assign ffs_word = (state_q == S_TWR) ? new_word : rdata;

  bbps_word_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i ({req_q.bucket, word_idx}),
    .wdata_i (new_word),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bbps_ffs u_ffs (
    .word_i (ffs_word),
    .zero_o (ffs_zero),
    .pos_o  (ffs_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      top_q       <= '0;
      lw_cur_q    <= '0;
      now_q       <= 1'b0;
      scan_q      <= '0;
      tscan_q     <= '0;
      bout_q      <= '0;
      low_q       <= '0;
      empty_q     <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBuckets; i++) begin
        lw_q[i] <= LwEmpty;
      end
    end else begin
      // S_OUT owns the valid flag while it is loading a response
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_req_i;
            now_q <= 1'b0;
            if (in_req_i.action == ActToggle) begin
              state_q <= S_TRD;
            end else if (in_req_i.action inside {ActLowest, ActPeek}) begin
              state_q <= S_QLW;
            end else begin
              // unused action: all-zero response
              bout_q  <= '0;
              low_q   <= '0;
              empty_q <= 1'b0;
              state_q <= S_OUT;
            end
          end
        end
        S_TRD: begin
          lw_cur_q <= lw_rd;
          state_q  <= S_TWR;
        end
        S_TWR: begin
          now_q   <= new_word[bit_idx];
          state_q <= S_TOP;
          if (new_word[bit_idx]) begin
            if (word_ext < lw_cur_q) begin
              lw_q[req_q.bucket] <= word_ext;
            end
          end else if (word_ext == lw_cur_q && ffs_zero) begin
            // lowest word emptied: scan upward for the next non-zero word
            if (next_word == LwEmpty) begin
              lw_q[req_q.bucket] <= LwEmpty;
            end else begin
              scan_q  <= next_word;
              state_q <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state_q <= S_SCK;
        end
        S_SCK: begin
          if (!ffs_zero) begin
            lw_q[req_q.bucket] <= scan_q;
            state_q            <= S_TOP;
          end else if (next_scan == LwEmpty) begin
            lw_q[req_q.bucket] <= LwEmpty;
            state_q            <= S_TOP;
          end else begin
            scan_q  <= next_scan;
            state_q <= S_SRD;
          end
        end
        S_TOP: begin
          state_q <= S_QLW;
          if (now_q) begin
            if (req_q.bucket > top_q) begin
              top_q <= req_q.bucket;
            end
          end else if (req_q.bucket == top_q) begin
            tscan_q <= req_q.bucket;
            state_q <= S_TSC;
          end
        end
        S_TSC: begin
          // walk down to the highest non-empty bucket, or bucket 0
          if (tscan_q == '0 || lw_rd != LwEmpty) begin
            top_q   <= tscan_q;
            state_q <= S_QLW;
          end else begin
            tscan_q <= tscan_q - BucketW'(1);
          end
        end
        S_QLW: begin
          bout_q   <= bout_sel;
          lw_cur_q <= lw_rd;
          state_q  <= S_QRD;
        end
        S_QRD: begin
          if (lw_cur_q == LwEmpty) begin
            low_q   <= LowEmpty;
            state_q <= S_EMP;
          end else begin
            state_q <= S_QFF;
          end
        end
        S_QFF: begin
          low_q   <= ffs_zero ? LowEmpty
                              : {1'b0, lw_cur_q[WordIdxW-1:0], ffs_pos};
          state_q <= S_EMP;
        end
        S_EMP: begin
          empty_q <= (lw_rd == LwEmpty);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.now_present   <= now_q;
            out_q.bucket_out    <= bout_q;
            out_q.lowest_member <= low_q;
            out_q.all_empty     <= empty_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== design/bbps_checker.sv =====
// Port-level checks of the bucket bitmap priority set, bound to the top level.
// Uses bbps_pkg.
module bbps_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input bbps_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bbps_pkg::rsp_t out_rsp_o
);
  import bbps_pkg::*;

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  a_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.lowest_member <= LowEmpty)
    else $error("lowest member out of range");

  // a value just set means the set is not empty
  a_present_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.now_present |-> !out_rsp_o.all_empty)
    else $error("set reported empty after insert");

endmodule

bind bucket_bitmap_priority_set_unit bbps_checker u_bbps_checker (.*);

// ===== sim/tb_bucket_bitmap_priority_set_unit.sv =====
// Testbench for bucket_bitmap_priority_set_unit. It predicts each response with its own
// model of the bucket bitmaps and checks every handshake field by field.
// Depends on bbps_pkg and the unit under test only.
`timescale 1ns / 100ps

module tb_bucket_bitmap_priority_set_unit;
  import bbps_pkg::*;

  localparam int          ClkHalf       = 5;
  localparam int          TimeoutCycles = 1_500_000;
  // Worst toggle: 7 word rescans plus 16 bucket steps
  localparam int          LatTail       = 48;
  localparam logic [1:0]  ActUnused     = 2'd3;

  typedef enum int {RxAlways, RxLight, RxHeavy} rx_mode_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready_o;
  req_t in_req;
  logic out_valid_o;
  logic out_ready;
  rsp_t out_rsp_o;

  // Predicted state of the set: one 32-bit word per (bucket, word index),
  // the lowest non-zero word per bucket (Words = empty) and the top bucket.
  logic [WordW-1:0]   set_words  [NumBuckets][Words];
  logic [LwW-1:0]     first_word [NumBuckets];
  logic [BucketW-1:0] top_bkt;

  rsp_t     pending_rsp_q[$];   // predicted responses, oldest first
  int       fail_cnt;

  // Sender and receiver pacing
  int       burst_left;
  bit       tx_gaps;
  rx_mode_e rx_mode;
  int       rx_hold_left;       // long receiver hold-off, counted down per cycle
  logic [31:0] rx_pattern;
  int       rx_tick;

  bucket_bitmap_priority_set_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  always #ClkHalf clk = ~clk;

  // ------------------------------------------------------------------------
  // Set predictor
  // ------------------------------------------------------------------------
  task automatic reset_sets();
    for (int b = 0; b < NumBuckets; b++) begin
      for (int w = 0; w < Words; w++) set_words[b][w] = '0;
      first_word[b] = LwEmpty;
    end
    top_bkt = '0;
  endtask

  function automatic bit bucket_is_empty(int unsigned b);
    return first_word[b] >= LwW'(Words);
  endfunction

  // Lowest member of a bucket, LowEmpty when the bucket holds nothing
  function automatic logic [LowW-1:0] lowest_of(logic [BucketW-1:0] b);
    logic [WordW-1:0] w;
    int unsigned pos;
    if (bucket_is_empty(b)) return LowEmpty;
    w = set_words[b][first_word[b][WordIdxW-1:0]];
    pos = 0;
    while (pos < WordW && !w[pos]) pos++;
    if (pos == WordW) return LowEmpty;
    return LowW'({first_word[b][WordIdxW-1:0], pos[BitW-1:0]});
  endfunction

  // Applies one request to the predicted state and returns its response
  function automatic rsp_t apply_req(req_t r);
    rsp_t rsp;
    logic [WordIdxW-1:0] n;
    logic [BitW-1:0] pos;
    logic now;
    int unsigned k;
    int t;
    bit known;
    rsp = '0;
    known = 1'b1;
    case (r.action)
      ActToggle: begin
        n = r.member[MemberW-1:BitW];
        pos = r.member[BitW-1:0];
        set_words[r.bucket][n][pos] = ~set_words[r.bucket][n][pos];
        now = set_words[r.bucket][n][pos];
        if (now) begin
          if (LwW'(n) < first_word[r.bucket]) first_word[r.bucket] = LwW'(n);
        end else if (LwW'(n) == first_word[r.bucket]) begin
          // lowest word went empty: rescan upward
          k = n;
          while (k < Words && set_words[r.bucket][k] == '0) k++;
          first_word[r.bucket] = LwW'(k);
        end
        if (now) begin
          if (r.bucket > top_bkt) top_bkt = r.bucket;
        end else if (r.bucket == top_bkt) begin
          // top went empty: step down to the next non-empty bucket, or 0
          t = r.bucket;
          while (t > 0 && bucket_is_empty(t)) t--;
          top_bkt = BucketW'(t);
        end
        rsp.now_present = now;
        rsp.bucket_out  = r.bucket;
      end
      ActLowest: rsp.bucket_out = r.bucket;
      ActPeek:   rsp.bucket_out = top_bkt;
      default:   known = 1'b0;    // unused action: all fields zero
    endcase
    if (known) begin
      rsp.lowest_member = lowest_of(rsp.bucket_out);
      rsp.all_empty     = bucket_is_empty(top_bkt);
    end
    return rsp;
  endfunction

  // ------------------------------------------------------------------------
  // Response checker and request monitor, both on the rising edge
  // ------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : mon
    rsp_t exp_rsp;
    if (rst_n) begin
      // check first, so a response and a request on the same edge stay ordered
      if (out_valid_o && out_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          exp_rsp = pending_rsp_q.pop_front();
          check_field("now_present", exp_rsp.now_present, out_rsp_o.now_present);
          check_field("bucket_out", exp_rsp.bucket_out, out_rsp_o.bucket_out);
          check_field("lowest_member", exp_rsp.lowest_member, out_rsp_o.lowest_member);
          check_field("all_empty", exp_rsp.all_empty, out_rsp_o.all_empty);
        end
      end
      if (in_valid && in_ready_o) pending_rsp_q.push_back(apply_req(in_req));
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: ready is always high, follows a random 32-bit pattern, or a long hold-off
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_mode == RxAlways) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_tick == 0)
        rx_pattern = (rx_mode == RxLight) ? ($urandom | $urandom) : $urandom;
      out_ready <= rx_pattern[rx_tick];
      rx_tick = (rx_tick + 1) % 32;
    end
  end

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------
  function automatic req_t mk_req(logic [1:0] act, int unsigned b, int unsigned m);
    req_t r;
    r.action = act;
    r.bucket = BucketW'(b);
    r.member = MemberW'(m);
    return r;
  endfunction

  // Drives one request and returns at the edge where it is accepted. Requests
  // go out in bursts; between bursts valid drops for a random gap if tx_gaps is set.
  task automatic send_req(input req_t r);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (tx_gaps)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
  endtask

  // Sender pauses until every predicted response has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (LatTail) @(posedge clk);
  endtask

  // Toggles off every member still present, top bucket first, so buckets
  // empty one by one and the top steps down repeatedly.
  task automatic clear_all_sets();
    for (int b = NumBuckets - 1; b >= 0; b--)
      for (int w = 0; w < Words; w++)
        for (int p = 0; p < WordW; p++)
          if (set_words[b][w][p]) send_req(mk_req(ActToggle, b, w * WordW + p));
  endtask

  function automatic int unsigned pick_member();
    // half the time land on a word boundary bit
    if ($urandom_range(0, 1))
      return $urandom_range(0, Words - 1) * WordW
             + ($urandom_range(0, 1) ? WordW - 1 : 0);
    return $urandom_range(0, ValueRange - 1);
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_mode = RxAlways;
    send_req(mk_req(ActPeek,   0, 0));      // peek with everything empty
    send_req(mk_req(ActLowest, 15, 255));   // empty bucket
    send_req(mk_req(ActUnused, 15, 255));   // unused action, all ones
    send_req(mk_req(ActToggle, 0, 0));
    send_req(mk_req(ActToggle, 15, 255));   // top rises to the last bucket
    send_req(mk_req(ActPeek,   0, 0));
    send_req(mk_req(ActToggle, 15, 255));   // top drops all the way to 0
    send_req(mk_req(ActPeek,   0, 0));
    send_req(mk_req(ActToggle, 0, 0));      // every bucket empty again
    send_req(mk_req(ActPeek,   9, 77));
    send_req(mk_req(ActToggle, 7, 200));
    send_req(mk_req(ActToggle, 7, 40));
    send_req(mk_req(ActToggle, 7, 31));
    send_req(mk_req(ActLowest, 7, 0));
    send_req(mk_req(ActToggle, 7, 31));     // lowest word empties, next is word 1
    send_req(mk_req(ActToggle, 7, 40));     // long rescan up to word 6
    send_req(mk_req(ActLowest, 7, 0));
    send_req(mk_req(ActToggle, 3, 32));
    send_req(mk_req(ActToggle, 7, 200));    // top steps down over empty buckets
    send_req(mk_req(ActPeek,   0, 0));
    send_req(mk_req(ActToggle, 3, 32));
    send_req(mk_req(ActUnused, 5, 170));
    send_req(mk_req(ActToggle, 0, 128));
    send_req(mk_req(ActToggle, 0, 128));
    wait_idle();
  endtask

  // Random requests over the whole field ranges; half of them are toggles
  task automatic test_random_mix();
    int unsigned sel;
    logic [1:0] act;
    tx_gaps = 1'b1;
    for (int i = 0; i < 900; i++) begin
      if (i % 100 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
      sel = $urandom_range(0, 15);
      act = (sel < 8) ? ActToggle : (sel < 11) ? ActLowest : (sel < 14) ? ActPeek : ActUnused;
      send_req(mk_req(act, $urandom_range(0, NumBuckets - 1),
                      $urandom_range(0, ValueRange - 1)));
    end
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // requests, so the unit fills up and stalls its input.
  task automatic test_rx_hold();
    tx_gaps = 1'b0;
    rx_mode = RxLight;
    rx_hold_left = 300;
    for (int i = 0; i < 16; i++)
      send_req(mk_req(ActToggle, $urandom_range(0, NumBuckets - 1), pick_member()));
    wait_idle();
  endtask

  // Small working sets in a few buckets so members get set and cleared again:
  // lowest-word rescans and top lowering happen often.
  task automatic test_bucket_churn();
    int unsigned bkts [3];
    int unsigned pool [5];
    int unsigned sel;
    clear_all_sets();
    for (int rnd = 0; rnd < 36; rnd++) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      tx_gaps = ($urandom_range(0, 3) != 0);
      foreach (bkts[j]) bkts[j] = $urandom_range(0, NumBuckets - 1);
      foreach (pool[j]) pool[j] = pick_member();
      for (int i = 0; i < 30; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)
          send_req(mk_req(ActToggle, bkts[$urandom_range(0, 2)], pool[$urandom_range(0, 4)]));
        else if (sel < 78)
          send_req(mk_req(ActLowest, bkts[$urandom_range(0, 2)], $urandom_range(0, 255)));
        else if (sel < 95)
          send_req(mk_req(ActPeek, $urandom_range(0, 15), $urandom_range(0, 255)));
        else
          send_req(mk_req(ActUnused, $urandom_range(0, 15), $urandom_range(0, 255)));
      end
      if (rnd % 8 == 7) wait_idle();
    end
    clear_all_sets();
    wait_idle();
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    out_ready    = 1'b0;
    fail_cnt     = 0;
    burst_left   = 0;
    tx_gaps      = 1'b0;
    rx_mode      = RxAlways;
    rx_hold_left = 0;
    rx_tick      = 0;
    rx_pattern   = '1;
    reset_sets();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_random_mix();
    test_rx_hold();
    test_bucket_churn();
    wait_idle();

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bbps_pkg.sv
design/bbps_word_ram.sv
design/bbps_ffs.sv
design/bucket_bitmap_priority_set_unit.sv
design/bbps_checker.sv
sim/tb_bucket_bitmap_priority_set_unit.sv
